FILE: design/ems_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ems_pkg;
  localparam int unsigned PosW = 24;
  localparam int unsigned TimeW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned EaseW = 17;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegStartPos = 3'd0;
  localparam logic [CfgIdxW-1:0] RegEndPos = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStartMs = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDuration = 3'd3;
  localparam logic [CfgIdxW-1:0] RegActive = 3'd4;

  // Selects which value an item finally takes.
  typedef enum logic [1:0] {
    SelEnd   = 2'd0,
    SelStart = 2'd1,
    SelBlend = 2'd2
  } pos_sel_e;

  typedef struct packed {
    logic signed [PosW-1:0] start_pos;
    logic signed [PosW-1:0] end_pos;
    pos_sel_e               sel;
    logic                   done;
  } item_ctl_t;
endpackage
`default_nettype wire

FILE: design/ems_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ems_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  modport source (output valid, output now_ms, input ready);
  modport sink (input valid, input now_ms, output ready);
endinterface

interface ems_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] position;
  logic               done_res;
  modport source (output valid, output position, output done_res, input ready);
  modport sink (input valid, input position, input done_res, output ready);
endinterface

interface ems_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: design/eased_move_setpoint.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes through stage 0, the divider, stages A to D and the output register.
// Throughput: one item per cycle unless the output stalls; the 16-stage divider sets the depth.
// The whole pipeline advances together and holds while the output stalls.
// Reset clears all valid bits and loads the register reset values;
// configuration writes are taken in every cycle.
module eased_move_setpoint (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ems_cfg_if.sink   cfg,
  ems_in_if.sink    in_ch,
  ems_out_if.source out_ch
);
  localparam int unsigned PW = ems_pkg::PosW;

  logic signed [PW-1:0] start_pos_q, end_pos_q;
  logic [31:0]          start_ms_q, dur_q;
  logic                 active_q;

  // Configuration registers.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pos_q <= '0;
      end_pos_q <= '0;
      start_ms_q <= '0;
      dur_q <= 32'd1;
      active_q <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        ems_pkg::RegStartPos: start_pos_q <= cfg.data[PW-1:0];
        ems_pkg::RegEndPos: end_pos_q <= cfg.data[PW-1:0];
        ems_pkg::RegStartMs: start_ms_q <= cfg.data;
        ems_pkg::RegDuration: dur_q <= (cfg.data == '0) ? 32'd1 : cfg.data;
        ems_pkg::RegActive: active_q <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Output register and global enable.
  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 0: classify the item and form the elapsed time.
  logic                s0_vld_q;
  logic [31:0]         s0_el_q, s0_dur_q;
  ems_pkg::item_ctl_t  s0_ctl_q;
  ems_pkg::item_ctl_t  ctl_c;
  logic [31:0]         el_c;
  always_comb begin
    el_c = in_ch.now_ms - start_ms_q;
    ctl_c.start_pos = start_pos_q;
    ctl_c.end_pos = end_pos_q;
    ctl_c.done = !active_q || (in_ch.now_ms >= start_ms_q + dur_q);
    if (!active_q) begin
      ctl_c.sel = ems_pkg::SelEnd;
    end else if (in_ch.now_ms < start_ms_q) begin
      ctl_c.sel = ems_pkg::SelStart;
    end else if (el_c >= dur_q) begin
      ctl_c.sel = ems_pkg::SelEnd;
    end else begin
      ctl_c.sel = ems_pkg::SelBlend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_ch.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_ctl_q <= ctl_c;
      // Out-of-range elapsed values would break the divider; their
      // quotient is unused, so feed zero.
      s0_el_q <= (ctl_c.sel == ems_pkg::SelBlend) ? el_c : '0;
      s0_dur_q <= dur_q;
    end
  end

  // Divider stages.
  logic               dv_vld;
  logic [15:0]        dv_t;
  ems_pkg::item_ctl_t dv_ctl;
  ems_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s0_vld_q),
    .num_i(s0_el_q), .den_i(s0_dur_q), .ctl_i(s0_ctl_q),
    .valid_o(dv_vld), .quot_o(dv_t), .ctl_o(dv_ctl)
  );

  // Stage A: pick the curve input and square it.
  logic               a_vld_q, a_hi_q;
  logic [16:0]        a_x_q;
  logic [33:0]        a_sq_q;
  ems_pkg::item_ctl_t a_ctl_q;
  logic [16:0]        x_c;
  assign x_c = dv_t[15] ? 17'(18'd131072 - {1'b0, dv_t, 1'b0}) : {1'b0, dv_t};

  // Stage B: cube.
  logic               b_vld_q, b_hi_q;
  logic [50:0]        b_cu_q;
  ems_pkg::item_ctl_t b_ctl_q;

  // Stage C: ease value and delta.
  logic               c_vld_q;
  logic [16:0]        c_e_q;
  logic signed [24:0] c_d_q;
  ems_pkg::item_ctl_t c_ctl_q;
  logic [16:0]        e_c;
  assign e_c = b_hi_q ? (17'd65536 - 17'(b_cu_q >> 33)) : 17'(b_cu_q >> 30);

  // Stage D: product.
  logic               d_vld_q;
  logic signed [42:0] d_p_q;
  ems_pkg::item_ctl_t d_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= dv_vld;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_x_q <= x_c;
      a_hi_q <= dv_t[15];
      a_sq_q <= x_c * x_c;
      a_ctl_q <= dv_ctl;
      b_cu_q <= a_sq_q * a_x_q;
      b_hi_q <= a_hi_q;
      b_ctl_q <= a_ctl_q;
      c_e_q <= e_c;
      c_d_q <= 25'(b_ctl_q.end_pos) - 25'(b_ctl_q.start_pos);
      c_ctl_q <= b_ctl_q;
      d_p_q <= c_d_q * $signed({1'b0, c_e_q});
      d_ctl_q <= c_ctl_q;
    end
  end

  // Stage E: round and select, into the output register.
  logic signed [42:0]   rnd_c;
  logic signed [PW-1:0] pos_c;
  assign rnd_c = (d_p_q + 43'sd32768) >>> 16;
  always_comb begin
    case (d_ctl_q.sel)
      ems_pkg::SelStart: pos_c = d_ctl_q.start_pos;
      ems_pkg::SelBlend: pos_c = d_ctl_q.start_pos + rnd_c[PW-1:0];
      default: pos_c = d_ctl_q.end_pos;
    endcase
  end

  logic signed [PW-1:0] out_pos_q;
  logic                 out_done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pos_q <= pos_c;
      out_done_q <= d_ctl_q.done;
    end
  end

  assign out_ch.valid = out_vld_q;
  assign out_ch.position = out_pos_q;
  assign out_ch.done_res = out_done_q;

`ifndef SYNTH
  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ch.ready |=> out_vld_q && $stable(out_pos_q))
    else $error("stalled result changed");
  // The input is ready whenever the output register is empty.
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_ch.ready)
    else $error("empty output blocked input");
  // A clear done flag in the last stage reaches the output unchanged.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_vld_q && en && !d_ctl_q.done |=> out_vld_q && !out_done_q)
    else $error("done flag lost");
`endif
endmodule
`default_nettype wire

FILE: design/ems_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider: quotient bits of (elapsed << 16) / duration,
// one bit per stage. Elapsed is known to be below the duration, so the
// quotient has exactly 16 bits. Control travels alongside.
module ems_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [ems_pkg::TimeW-1:0]      num_i,
  input  wire logic [ems_pkg::TimeW-1:0]      den_i,
  input  wire ems_pkg::item_ctl_t             ctl_i,
  output logic                                valid_o,
  output logic [ems_pkg::FracW-1:0]           quot_o,
  output ems_pkg::item_ctl_t                  ctl_o
);
  localparam int unsigned N = ems_pkg::FracW;
  localparam int unsigned RW = ems_pkg::TimeW + 1;

  logic [N:1]                   vld_q;
  logic [RW-1:0]                rem_q [1:N-1];
  logic [ems_pkg::TimeW-1:0]    den_q [1:N-1];
  logic [N-1:0]                 quo_q [1:N];
  ems_pkg::item_ctl_t           ctl_q [1:N];

  // One quotient bit per stage.
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic                      vld_in;
    logic [RW-1:0]             rem_in;
    logic [ems_pkg::TimeW-1:0] den_in;
    logic [N-1:0]              quo_in;
    ems_pkg::item_ctl_t        ctl_in;
    logic [RW-1:0]             shifted;
    logic [RW-1:0]             diff;
    logic                      ge;

    // The first stage takes the item straight from the inputs.
    if (s == 0) begin : g_head
      assign vld_in = valid_i;
      assign rem_in = {1'b0, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
      assign ctl_in = ctl_i;
    end else begin : g_body
      assign vld_in = vld_q[s];
      assign rem_in = rem_q[s];
      assign den_in = den_q[s];
      assign quo_in = quo_q[s];
      assign ctl_in = ctl_q[s];
    end

    assign shifted = {rem_in[RW-2:0], 1'b0};
    assign ge = shifted >= {1'b0, den_in};
    assign diff = shifted - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s+1] <= {quo_in[N-2:0], ge};
        ctl_q[s+1] <= ctl_in;
      end
    end

    // The remainder and divisor are only needed by a following stage.
    if (s < N - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1] <= ge ? diff : shifted;
          den_q[s+1] <= den_in;
        end
      end
    end
  end

  assign valid_o = vld_q[N];
  assign quot_o = quo_q[N];
  assign ctl_o = ctl_q[N];
endmodule
`default_nettype wire

FILE: tb/sv/tb_eased_move_setpoint.sv
`timescale 1ns / 1ps
module tb_eased_move_setpoint;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ems_cfg_if cfg ();
  ems_in_if in_ch ();
  ems_out_if out_ch ();

  eased_move_setpoint i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg   (cfg.sink),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic signed [ems_pkg::PosW-1:0] position;
    logic                            done;
  } setpoint_t;

  // Shadow copy of the move registers.
  logic signed [ems_pkg::PosW-1:0] mv_start_pos;
  logic signed [ems_pkg::PosW-1:0] mv_end_pos;
  logic [ems_pkg::TimeW-1:0]       mv_start_ms;
  logic [ems_pkg::TimeW-1:0]       mv_duration;
  logic                            mv_active;

  setpoint_t pending_setpoints[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_off = 1'b0;

  // Cubic in-out ease in Q1.16.
  function automatic logic [63:0] ease_of(input logic [63:0] t);
    logic [63:0] f;
    if (t < 64'd32768) begin
      return (t * t * t) >> 30;
    end
    f = 64'd131072 - 2 * t;
    return 64'd65536 - ((f * f * f) >> 33);
  endfunction

  // Expected setpoint for one timestamp.
  function automatic setpoint_t setpoint_at(input logic [ems_pkg::TimeW-1:0] now);
    setpoint_t r;
    logic [ems_pkg::TimeW-1:0] elapsed;
    logic [ems_pkg::TimeW-1:0] end_ms;
    logic [63:0] t;
    longint a;
    longint b;
    longint prod;
    longint q;
    longint p;
    a = longint'(mv_start_pos);
    b = longint'(mv_end_pos);
    if (!mv_active) begin
      r.position = mv_end_pos;
      r.done = 1'b1;
      return r;
    end
    end_ms = mv_start_ms + mv_duration;
    r.done = (now >= end_ms);
    if (now < mv_start_ms) begin
      r.position = mv_start_pos;
    end else begin
      elapsed = now - mv_start_ms;
      if (elapsed >= mv_duration) begin
        r.position = mv_end_pos;
      end else begin
        t = ({32'd0, elapsed} << 16) / {32'd0, mv_duration};
        prod = (b - a) * longint'(ease_of(t));
        // Round half up: arithmetic shift floors.
        q = (prod + 32768) >>> 16;
        p = a + q;
        r.position = p[ems_pkg::PosW-1:0];
      end
    end
    return r;
  endfunction

  // Write one register and mirror it in the shadow copy.
  task automatic write_reg(input logic [ems_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      ems_pkg::RegStartPos: mv_start_pos = val[ems_pkg::PosW-1:0];
      ems_pkg::RegEndPos: mv_end_pos = val[ems_pkg::PosW-1:0];
      ems_pkg::RegStartMs: mv_start_ms = val;
      ems_pkg::RegDuration: mv_duration = (val == 0) ? 32'd1 : val;
      ems_pkg::RegActive: mv_active = val[0];
      default: ;
    endcase
    // The extra wait after dropping valid keeps the next write in a later time step.
    @(posedge clk_i);
  endtask

  task automatic write_move(input logic [31:0] sp, input logic [31:0] ep,
                            input logic [31:0] st, input logic [31:0] dur,
                            input logic [31:0] act);
    write_reg(ems_pkg::RegStartPos, sp);
    write_reg(ems_pkg::RegEndPos, ep);
    write_reg(ems_pkg::RegStartMs, st);
    write_reg(ems_pkg::RegDuration, dur);
    write_reg(ems_pkg::RegActive, act);
  endtask

  // Offer one timestamp and record its expected setpoint when accepted.
  // Valid stays high after acceptance so items can follow back to back;
  // an idle cycle or the drain drops it.
  task automatic send_time(input logic [ems_pkg::TimeW-1:0] now, input bit has_exp,
                           input setpoint_t exp_sp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.now_ms <= now;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_setpoints.push_back(has_exp ? exp_sp : setpoint_at(now));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_setpoints.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0: return 32'h7FFFFF;
      1: return 32'h800000;
      default: return $urandom;
    endcase
  endfunction

  // Random timestamp, mostly around the configured move.
  function automatic logic [31:0] rand_now();
    case ($urandom_range(9))
      0: return $urandom;
      1: return mv_start_ms - $urandom_range(3);
      2: return mv_start_ms + mv_duration + $urandom_range(3) - 1;
      default: return mv_start_ms + ($urandom % mv_duration);
    endcase
  endfunction

  // Receiver: random stalls and one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_setpoints.size() == 0) begin
        $display("%0t: unexpected result pos=%0d done=%0b", $time,
                 out_ch.position, out_ch.done_res);
        fail_count++;
      end else begin
        setpoint_t e;
        e = pending_setpoints.pop_front();
        if (out_ch.position !== e.position) begin
          $display("%0t: position expected %0d actual %0d", $time, e.position,
                   out_ch.position);
          fail_count++;
        end
        if (out_ch.done_res !== e.done) begin
          $display("%0t: done expected %0b actual %0b", $time, e.done,
                   out_ch.done_res);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  typedef struct {
    logic [31:0] now;
    bit          has_exp;
    setpoint_t   exp_sp;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    int unsigned ph;
    in_ch.valid = 1'b0;
    in_ch.now_ms = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    mv_start_pos = '0;
    mv_end_pos = '0;
    mv_start_ms = '0;
    mv_duration = 32'd1;
    mv_active = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset: inactive move gives end position 0 and done.
    rows = '{'{32'd0, 1, '{24'sd0, 1'b1}}, '{32'hFFFFFFFF, 1, '{24'sd0, 1'b1}}};
    foreach (rows[i]) send_time(rows[i].now, rows[i].has_exp, rows[i].exp_sp);
    drain();

    // Full-scale move; zero duration is stored as one.
    write_move(32'h800000, 32'h7FFFFF, 32'd1000, 32'd0, 32'd1);
    rows = '{'{32'd999, 1, '{-24'sd8388608, 1'b0}}, '{32'd1000, 1, '{-24'sd8388608, 1'b0}},
             '{32'd1001, 1, '{24'sd8388607, 1'b1}}, '{32'd0, 1, '{-24'sd8388608, 1'b0}}};
    foreach (rows[i]) send_time(rows[i].now, rows[i].has_exp, rows[i].exp_sp);
    drain();

    // Long move; end time wraps past 2^32.
    write_move(32'h7FFFFF, 32'h800000, 32'hFFFFFF00, 32'hFFFFFFFF, 32'd1);
    rows = '{'{32'hFFFFFEFF, 1, '{24'sd8388607, 1'b1}}, '{32'hFFFFFF00, 0, '0},
             '{32'hFFFFFF80, 0, '0}, '{32'hFFFFFFFF, 0, '0},
             '{32'h0, 1, '{24'sd8388607, 1'b0}}};
    foreach (rows[i]) send_time(rows[i].now, rows[i].has_exp, rows[i].exp_sp);
    drain();

    // Midpoint and both halves of the curve; an unknown index is ignored.
    write_move(32'd0, 32'd65536, 32'd0, 32'd1000, 32'd1);
    write_reg(3'd7, 32'hFFFFFFFF);
    rows = '{'{32'd0, 1, '{24'sd0, 1'b0}}, '{32'd250, 0, '0}, '{32'd500, 0, '0},
             '{32'd501, 0, '0}, '{32'd999, 0, '0},
             '{32'd1000, 1, '{24'sd65536, 1'b1}}};
    foreach (rows[i]) send_time(rows[i].now, rows[i].has_exp, rows[i].exp_sp);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (60) send_time(rand_now(), 0, '0);
    join
    drain();

    // Random moves over the idling phases.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 61; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 61; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      repeat (3) begin
        write_move(rand_pos(), rand_pos(), $urandom,
                   ($urandom_range(3) == 0) ? $urandom : $urandom_range(2000),
                   ($urandom_range(5) != 0));
        repeat (36) send_time(rand_now(), 0, '0);
        drain();
      end
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
